// ----- rtl/fixed_point_alu_q24_8_defines.svh -----
// Assertion macros shared by the fixed-point ALU RTL files.
// Depends on nothing; included by the modules that assert.
`ifndef FIXED_POINT_ALU_Q24_8_DEFINES_SVH
`define FIXED_POINT_ALU_Q24_8_DEFINES_SVH
`ifndef SYNTHESIS
`define FPA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPA_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPA_ASSERT(label, clk, rst_n, prop, msg)
`define FPA_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ----- rtl/fpa_pkg.sv -----
// Package for the fixed-point ALU: payload structs, operation, error and class codes, widths.
// Depends on nothing.
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;
  localparam int DATA_W = 32;
  localparam int DIV_W = DATA_W + 16 + 2;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_MIN = 4'd4,
    OP_MAX = 4'd5, OP_INC = 4'd6, OP_DEC = 4'd7, OP_TO_INT = 4'd8, OP_FROM_INT = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_DIV_ZERO = 2'd1, ERR_OVERFLOW = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0, CLS_MUL = 2'd1, CLS_DIV = 2'd2
  } cls_t;

  typedef struct packed {
    logic [3:0]                kind;
    logic signed [DATA_W-1:0]  operand_a;
    logic signed [DATA_W-1:0]  operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  result_value;
    logic                      a_less;
    logic                      a_equal;
    logic                      a_greater;
    logic [1:0]                error_code;
  } out_item_t;

  typedef struct packed {
    cls_t                      cls;
    logic                      neg;
    logic [DATA_W-1:0]         mag_a;
    logic [DATA_W-1:0]         mag_b;
    logic signed [DATA_W-1:0]  simple_val;
    logic [1:0]                simple_err;
    logic                      a_less;
    logic                      a_equal;
    logic                      a_greater;
  } job_t;

endpackage

// ----- rtl/fpa_front.sv -----
// Front end: decodes the operation, computes simple results, flags and magnitudes combinationally.
// Depends on fpa_pkg.
module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
  input  fpa_pkg::in_item_t item,
  output fpa_pkg::job_t     job
);
  import fpa_pkg::*;

  localparam int SAT_BITS = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
  localparam int EXT_W = DATA_W + 16 + 2;
  localparam logic signed [EXT_W-1:0] SAT_HI = (EXT_W'(1) <<< (SAT_BITS - 1)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);

  logic signed [EXT_W-1:0] a_x, b_x, raw;
  logic signed [DATA_W-1:0] a, b;
  logic do_sat;
  cls_t cls;
  logic signed [DATA_W-1:0] simple_val;
  logic [1:0] simple_err;

  assign a = item.operand_a;
  assign b = item.operand_b;
  assign a_x = EXT_W'(a);
  assign b_x = EXT_W'(b);

  always_comb begin
    raw = '0;
    do_sat = 1'b1;
    cls = CLS_SIMPLE;
    unique case (item.kind)
      OP_ADD:      raw = a_x + b_x;
      OP_SUB:      raw = a_x - b_x;
      OP_MUL:      cls = CLS_MUL;
      OP_DIV:      cls = CLS_DIV;
      OP_MIN: begin
        raw = (a < b) ? a_x : b_x;
        do_sat = 1'b0;
      end
      OP_MAX: begin
        raw = (a > b) ? a_x : b_x;
        do_sat = 1'b0;
      end
      OP_INC:      raw = a_x + EXT_W'(1);
      OP_DEC:      raw = a_x - EXT_W'(1);
      OP_TO_INT: begin
        raw = a_x >>> FRAC_BITS;
        do_sat = 1'b0;
      end
      OP_FROM_INT: raw = a_x <<< FRAC_BITS;
      default: begin
        raw = '0;
        do_sat = 1'b0;
      end
    endcase
  end

  always_comb begin
    simple_err = ERR_NONE;
    simple_val = DATA_W'(raw);
    if (do_sat && raw > SAT_HI) begin
      simple_val = DATA_W'(SAT_HI);
      simple_err = ERR_OVERFLOW;
    end else if (do_sat && raw < SAT_LO) begin
      simple_val = DATA_W'(SAT_LO);
      simple_err = ERR_OVERFLOW;
    end
  end

  assign job.cls = cls;
  assign job.simple_val = simple_val;
  assign job.simple_err = simple_err;
  assign job.neg = a[DATA_W-1] ^ b[DATA_W-1];
  assign job.mag_a = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
  assign job.mag_b = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
  assign job.a_less = a < b;
  assign job.a_equal = a == b;
  assign job.a_greater = a > b;

endmodule

// ----- rtl/fpa_queue.sv -----
// Two-entry queue between front and back ends.
// Depends on fpa_pkg and the assertion macro header.
module fpa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  fpa_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output fpa_pkg::job_t rd_data
);
  import fpa_pkg::*;
  `include "fixed_point_alu_q24_8_defines.svh"

  job_t mem_r [2];
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  `FPA_ASSERT(a_q_cnt_max, clk, rst_n, cnt_r != 2'd3, "queue count out of range")
  `FPA_ASSERT(a_q_full_hold, clk, rst_n, (cnt_r == 2'd2 && !rd_ready) |=> cnt_r == 2'd2, "full queue drained without pop")
  `FPA_ASSERT(a_q_ptr, clk, rst_n, (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r, "queue pointers disagree with count")

endmodule

// ----- rtl/fpa_back.sv -----
// Back end: pipelined multiplier and radix-2 restoring divider, one stage
// per quotient bit, rounding, saturation and an output register.
// Depends on fpa_pkg and the assertion macro header.
module fpa_back #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  fpa_pkg::job_t      job,
  output logic               out_valid,
  input  logic               out_ready,
  output fpa_pkg::out_item_t out_item
);
  import fpa_pkg::*;
  `include "fixed_point_alu_q24_8_defines.svh"

  localparam int SAT_BITS = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
  localparam int QW = DATA_W + FRAC_BITS + 1;
  localparam int NW = DATA_W + QW + 2;
  localparam int DEPTH = QW + 2;
  localparam int HW = DATA_W / 2;
  localparam int PPW = DATA_W + HW;
  localparam logic [NW-1:0] SAT_HI = (NW'(1) << (SAT_BITS - 1)) - NW'(1);
  localparam logic [NW-1:0] SAT_LO_MAG = NW'(1) << (SAT_BITS - 1);

  typedef struct packed {
    logic              vld;
    cls_t              cls;
    logic              neg;
    logic              zero_div;
    logic [NW-1:0]     rem;
    logic [NW-1:0]     den;
    logic [NW-1:0]     quo;
    logic [DATA_W-1:0] mb;
    logic signed [DATA_W-1:0] simple_val;
    logic [1:0]        simple_err;
    logic [2:0]        cmp;
  } stg_t;

  stg_t st_r [DEPTH];
  stg_t st_nxt [DEPTH];
  logic [PPW-1:0] pp_lo, pp_hi, pp_lo_r, pp_hi_r;
  logic adv;
  out_item_t res_nxt, out_r;
  logic out_v_r;
  logic [NW-1:0] mag_fin;

  assign out_valid = out_v_r;
  assign out_item = out_r;
  assign adv = !out_v_r || out_ready;
  assign job_ready = adv;

  always_comb begin
    st_nxt[0] = '0;
    st_nxt[0].vld = job_valid;
    st_nxt[0].cls = job.cls;
    st_nxt[0].neg = job.neg;
    st_nxt[0].zero_div = job.mag_b == '0;
    st_nxt[0].rem = NW'({job.mag_a, 1'b0}) << FRAC_BITS;
    st_nxt[0].den = NW'({job.mag_b, 1'b0});
    st_nxt[0].mb = job.mag_b;
    st_nxt[0].quo = NW'(job.mag_a);
    st_nxt[0].simple_val = job.simple_val;
    st_nxt[0].simple_err = job.simple_err;
    st_nxt[0].cmp = {job.a_less, job.a_equal, job.a_greater};
    st_nxt[0].rem = st_nxt[0].rem + NW'(job.mag_b);
    for (int i = 1; i < DEPTH; i++) begin
      st_nxt[i] = st_r[i-1];
    end
    for (int i = 1; i <= QW; i++) begin
      if (st_r[i-1].cls == CLS_DIV) begin
        if (st_r[i-1].rem >= (st_r[i-1].den << (QW - i))) begin
          st_nxt[i].rem = st_r[i-1].rem - (st_r[i-1].den << (QW - i));
          st_nxt[i].quo = st_r[i-1].quo | (NW'(1) << (QW - i));
        end
      end
    end
    st_nxt[1].quo = (st_r[0].cls == CLS_DIV) ? st_nxt[1].quo : st_r[0].quo;
    if (st_r[0].cls == CLS_DIV) begin
      st_nxt[1].quo = (st_r[0].rem >= (st_r[0].den << (QW - 1)))
                      ? (NW'(1) << (QW - 1)) : '0;
    end
    if (st_r[1].cls == CLS_MUL) begin
      st_nxt[2].quo = (NW'(pp_lo_r) + (NW'(pp_hi_r) << HW)
                       + NW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    end
  end

  assign pp_lo = PPW'(st_r[0].quo[DATA_W-1:0]) * PPW'(st_r[0].mb[HW-1:0]);
  assign pp_hi = PPW'(st_r[0].quo[DATA_W-1:0]) * PPW'(st_r[0].mb[DATA_W-1:HW]);

  always_ff @(posedge clk) begin
    if (adv) begin
      pp_lo_r <= pp_lo;
      pp_hi_r <= pp_hi;
    end
  end

  always_comb begin
    stg_t t;
    logic [NW-1:0] prod;
    t = st_r[DEPTH-1];
    prod = '0;
    mag_fin = t.quo;
    if (t.cls == CLS_MUL) begin
      mag_fin = t.quo;
    end
    res_nxt.a_less = t.cmp[2];
    res_nxt.a_equal = t.cmp[1];
    res_nxt.a_greater = t.cmp[0];
    res_nxt.error_code = t.simple_err;
    res_nxt.result_value = t.simple_val;
    if (t.cls != CLS_SIMPLE) begin
      res_nxt.error_code = ERR_NONE;
      if (t.cls == CLS_DIV && t.zero_div) begin
        res_nxt.result_value = '0;
        res_nxt.error_code = ERR_DIV_ZERO;
      end else if (!t.neg && mag_fin > SAT_HI) begin
        res_nxt.result_value = DATA_W'(SAT_HI);
        res_nxt.error_code = ERR_OVERFLOW;
      end else if (t.neg && mag_fin > SAT_LO_MAG) begin
        res_nxt.result_value = DATA_W'(-SAT_LO_MAG);
        res_nxt.error_code = ERR_OVERFLOW;
      end else begin
        prod = t.neg ? -mag_fin : mag_fin;
        res_nxt.result_value = DATA_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        st_r[i].vld <= 1'b0;
      end
      out_v_r <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < DEPTH; i++) begin
        st_r[i] <= st_nxt[i];
      end
      out_v_r <= st_r[DEPTH-1].vld;
      out_r <= res_nxt;
    end
  end

  `FPA_ASSERT(a_b_stall_hold, clk, rst_n, (out_v_r && !out_ready) |=> $stable(out_r), "result changed while stalled")
  `FPA_ASSERT(a_b_ready, clk, rst_n, job_ready == (!out_v_r || out_ready), "back ready mismatch")
  `FPA_ASSERT(a_b_flags, clk, rst_n, out_v_r |-> $onehot({out_r.a_less, out_r.a_equal, out_r.a_greater}), "compare flags not one-hot")

endmodule

// ----- rtl/fixed_point_alu_q24_8.sv -----
// Signed Q24.8 fixed-point ALU. One item is accepted per cycle while the queue
// has room; results leave in order through the queue, the back-end stages and
// the output register, and are held while the output stalls. The divider
// pipeline (one quotient bit per stage) sets the back-end depth. Multiply and
// divide round half away from zero; overflow saturates with error code 2.
module fixed_point_alu_q24_8 #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fpa_pkg::out_item_t out_data
);
  import fpa_pkg::*;

  job_t f_job, q_job;
  logic q_valid, q_ready;

  fpa_front #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_front (
    .item(in_data), .job(f_job)
  );

  fpa_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(f_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
  );

  fpa_back #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_data)
  );

endmodule

// ----- test/fixed_point_alu_q24_8_tb.sv -----
// Testbench for the Q24.8 fixed-point ALU: directed corners, then random beats with idling.
// Depends on fpa_pkg and fixed_point_alu_q24_8; a scoreboard class predicts each result.
module fixed_point_alu_q24_8_tb;
  import fpa_pkg::*;

  localparam int FRAC = 8;
  localparam int N_RANDOM = 1930;
  localparam int LATENCY = FRAC + DATA_W + 4;
  localparam int STALL_LIMIT = 2000;

  class alu_scoreboard;
    out_item_t pending[$];
    int errors;
    int checked;

    function automatic longint unsigned mag64(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function automatic longint sat32(longint v, ref logic [1:0] err);
      if (v > 64'sd2147483647) begin
        err = ERR_OVERFLOW;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        err = ERR_OVERFLOW;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function void note_beat(in_item_t it);
      longint a, b, r;
      longint unsigned p, q, n, d;
      logic [1:0] err;
      out_item_t o;
      a = it.operand_a;
      b = it.operand_b;
      r = 0;
      err = ERR_NONE;
      case (it.kind)
        OP_ADD: r = sat32(a + b, err);
        OP_SUB: r = sat32(a - b, err);
        OP_MUL: begin
          p = mag64(a) * mag64(b);
          q = (p + (64'd1 << (FRAC - 1))) >> FRAC;
          r = ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
          r = sat32(r, err);
        end
        OP_DIV: begin
          if (b == 0) begin
            err = ERR_DIV_ZERO;
          end else begin
            n = mag64(a) << FRAC;
            d = mag64(b);
            q = (2 * n + d) / (2 * d);
            r = ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
            r = sat32(r, err);
          end
        end
        OP_MIN: r = (a < b) ? a : b;
        OP_MAX: r = (a > b) ? a : b;
        OP_INC: r = sat32(a + 1, err);
        OP_DEC: r = sat32(a - 1, err);
        OP_TO_INT: r = a >>> FRAC;
        OP_FROM_INT: r = sat32(a * (64'sd1 << FRAC), err);
        default: r = 0;
      endcase
      o.result_value = r[31:0];
      o.a_less = a < b;
      o.a_equal = a == b;
      o.a_greater = a > b;
      o.error_code = err;
      pending.push_back(o);
    endfunction

    function void check_beat(out_item_t got);
      out_item_t exp_item;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing outstanding: %h", $time, got);
        errors++;
        return;
      end
      exp_item = pending.pop_front();
      checked++;
      if (got.result_value !== exp_item.result_value ||
          got.a_less !== exp_item.a_less || got.a_equal !== exp_item.a_equal ||
          got.a_greater !== exp_item.a_greater ||
          got.error_code !== exp_item.error_code) begin
        $display("%0t: mismatch exp val=%h lt=%b eq=%b gt=%b err=%0d got val=%h lt=%b eq=%b gt=%b err=%0d",
                 $time, exp_item.result_value, exp_item.a_less, exp_item.a_equal,
                 exp_item.a_greater, exp_item.error_code, got.result_value, got.a_less,
                 got.a_equal, got.a_greater, got.error_code);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  alu_scoreboard sb = new();
  int idle_pct = 23;
  int stall_count = 0;
  int beats_in = 0;

  fixed_point_alu_q24_8 i_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_beat(in_data);
        beats_in++;
      end
      if (out_valid && out_ready) sb.check_beat(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (!in_valid && sb.pending.size() == 0)) begin
        stall_count <= 0;
      end else begin
        stall_count <= stall_count + 1;
      end
      if (stall_count >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("fixed_point_alu_q24_8 regression: fail");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'($urandom_range(2048)) - 32'd1024;
      4: return 32'($urandom_range(24'hffffff)) - 32'h00800000;
      5: return {16'($urandom_range(65535)), 16'h0} ^ {16'h0, 16'($urandom_range(65535))};
      default: return $urandom();
    endcase
  endfunction

  task automatic send_beat(logic [3:0] kind, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{kind: kind, operand_a: a, operand_b: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [3:0] k;
    logic [31:0] a, b;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_beat(OP_ADD, 32'h7fffffff, 32'h1);
    send_beat(OP_ADD, 32'h80000000, 32'h80000000);
    send_beat(OP_SUB, 32'h80000000, 32'h1);
    send_beat(OP_SUB, 32'h7fffffff, 32'hffffffff);
    send_beat(OP_MUL, 32'h00000180, 32'hffffff80);
    send_beat(OP_MUL, 32'h80000000, 32'h80000000);
    send_beat(OP_MUL, 32'h00000001, 32'h00000080);
    send_beat(OP_MUL, 32'hffffffff, 32'h00000080);
    send_beat(OP_DIV, 32'h00000100, 32'h0);
    send_beat(OP_DIV, 32'h80000000, 32'h00000001);
    send_beat(OP_DIV, 32'h00000001, 32'h00000200);
    send_beat(OP_DIV, 32'h80000000, 32'h80000000);
    send_beat(OP_DIV, 32'hffffffff, 32'h00000003);
    send_beat(OP_MIN, 32'h80000000, 32'h7fffffff);
    send_beat(OP_MAX, 32'h00000005, 32'h00000005);
    send_beat(OP_INC, 32'h7fffffff, 32'h0);
    send_beat(OP_DEC, 32'h80000000, 32'h0);
    send_beat(OP_TO_INT, 32'hffffff01, 32'h0);
    send_beat(OP_TO_INT, 32'h7fffffff, 32'h0);
    send_beat(OP_FROM_INT, 32'h00800000, 32'h0);
    send_beat(OP_FROM_INT, 32'hff7fffff, 32'h0);
    send_beat(OP_FROM_INT, 32'h007fffff, 32'h0);
    send_beat(4'd10, 32'h1, 32'h2);
    send_beat(4'd15, 32'h80000000, 32'h7fffffff);
    for (int i = 0; i < N_RANDOM; i++) begin
      idle_pct = (i >= 600 && i < 900) ? 0 : 23;
      k = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
      a = pick_operand();
      b = ($urandom_range(7) == 0) ? a : pick_operand();
      send_beat(k, a, b);
    end
    idle_pct = 23;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d beats over all ten operations and unknown codes; checked %0d results.",
             beats_in, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("fixed_point_alu_q24_8 regression: pass");
    end else begin
      $display("fixed_point_alu_q24_8 regression: fail");
    end
    $finish;
  end
endmodule
